// ===== hdl/dthm_pkg.sv =====
// ----------------------------------------------------------------------------
// dthm_pkg
// Shared constants, types and helper functions of the degenerate tetramer
// hit merger.
// ----------------------------------------------------------------------------
package dthm_pkg;

  localparam int POS_BITS    = 32;
  localparam int OUT_BITS    = 32;
  localparam int MASK_BITS   = 4;
  localparam int CODE_BITS   = 3;
  localparam int HIST_DEPTH  = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_BITS   = 4;
  localparam int DATA_BITS   = 32;

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  // base codes
  localparam logic [CODE_BITS-1:0] CODE_A       = 3'd0;
  localparam logic [CODE_BITS-1:0] CODE_C       = 3'd1;
  localparam logic [CODE_BITS-1:0] CODE_G       = 3'd2;
  localparam logic [CODE_BITS-1:0] CODE_T       = 3'd3;
  localparam logic [CODE_BITS-1:0] CODE_NOMATCH = 3'd4;

  // ASCII bytes that carry a base
  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_G = 8'h47;
  localparam logic [7:0] CHAR_T = 8'h54;

  // register indexes
  localparam logic [1:0] REG_POS0 = 2'd0;
  localparam logic [1:0] REG_POS1 = 2'd1;
  localparam logic [1:0] REG_POS2 = 2'd2;
  localparam logic [1:0] REG_POS3 = 2'd3;

  localparam logic [MASK_BITS-1:0] MASK_RESET = 4'd1;

  typedef struct packed {
    logic [MASK_BITS-1:0] pos0;
    logic [MASK_BITS-1:0] pos1;
    logic [MASK_BITS-1:0] pos2;
    logic [MASK_BITS-1:0] pos3;
  } dthm_masks_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] run_first;
    logic [OUT_BITS-1:0] run_final;
    logic                last_of_item;
  } dthm_result_t;

  // results of one item on their way into the queue
  typedef struct packed {
    logic [1:0]   num;
    dthm_result_t r0;
    dthm_result_t r1;
  } dthm_push_t;

  function automatic logic [CODE_BITS-1:0] base_code(input logic [7:0] c);
    logic [CODE_BITS-1:0] r;
    case (c)
      CHAR_A:  r = CODE_A;
      CHAR_C:  r = CODE_C;
      CHAR_G:  r = CODE_G;
      CHAR_T:  r = CODE_T;
      default: r = CODE_NOMATCH;
    endcase
    return r;
  endfunction

  function automatic logic allowed(input logic [CODE_BITS-1:0] code,
                                   input logic [MASK_BITS-1:0] mask);
    return (code < CODE_NOMATCH) && mask[code[1:0]];
  endfunction

  // zero-extend or truncate a position to the result width
  function automatic logic [OUT_BITS-1:0] to_out(input logic [POS_BITS-1:0] p);
    logic [POS_BITS+OUT_BITS-1:0] w;
    w = {{OUT_BITS{1'b0}}, p};
    return w[OUT_BITS-1:0];
  endfunction

endpackage

// ===== hdl/dthm_in_if.sv =====
// ----------------------------------------------------------------------------
// dthm_in_if
// Sequence byte channel: valid/ready handshake with one byte per item.
// ----------------------------------------------------------------------------
interface dthm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] base_char;
  logic       seq_end;

  modport source (output valid, output base_char, output seq_end, input ready);
  modport sink   (input valid, input base_char, input seq_end, output ready);
endinterface

// ===== hdl/dthm_out_if.sv =====
// ----------------------------------------------------------------------------
// dthm_out_if
// Hit run channel: valid/ready handshake with one merged run per item.
// ----------------------------------------------------------------------------
interface dthm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] run_first;
  logic [31:0] run_final;
  logic        last_of_item;

  modport source (output valid, output run_first, output run_final,
                  output last_of_item, input ready);
  modport sink   (input valid, input run_first, input run_final,
                  input last_of_item, output ready);
endinterface

// ===== hdl/dthm_front.sv =====
// ----------------------------------------------------------------------------
// dthm_front
// Accept sequence bytes, match the four-base window and merge hits into runs.
// ----------------------------------------------------------------------------
module dthm_front import dthm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  dthm_masks_t masks,
  input  logic        space_ok,
  dthm_in_if.sink     seq_in,
  output logic        push,
  output dthm_push_t  push_data
);

  logic [CODE_BITS-1:0] recent [HIST_DEPTH];
  logic [POS_BITS-1:0]  position_count;
  logic                 run_open;
  logic [POS_BITS-1:0]  run_begin;
  logic [POS_BITS-1:0]  run_stop;

  logic                 run_open_next;
  logic [POS_BITS-1:0]  run_begin_next;
  logic [POS_BITS-1:0]  run_stop_next;
  logic [CODE_BITS-1:0] code;
  logic                 hit;
  logic                 joins;
  logic                 emit_old;
  logic                 flush;
  logic                 accept;
  logic [POS_BITS:0]    stop_reach;

  assign seq_in.ready = space_ok;
  assign accept       = seq_in.valid && space_ok;
  assign code         = base_code(seq_in.base_char);

  assign hit = allowed(recent[0], masks.pos0) && allowed(recent[1], masks.pos1) &&
               allowed(recent[2], masks.pos2) && allowed(code, masks.pos3) &&
               (position_count >= POS_BITS'(3));

  // offset p-3 joins when p-3 <= stop+1, i.e. p <= stop+4
  assign stop_reach = {1'b0, run_stop} + (POS_BITS+1)'(4);
  assign joins      = run_open && ({1'b0, position_count} <= stop_reach);
  assign emit_old   = hit && run_open && !joins;

  always_comb begin
    run_open_next  = run_open;
    run_begin_next = run_begin;
    run_stop_next  = run_stop;
    if (hit) begin
      if (joins) begin
        if (position_count > run_stop) begin
          run_stop_next = position_count;
        end
      end else begin
        run_open_next  = 1'b1;
        run_begin_next = position_count - POS_BITS'(3);
        run_stop_next  = position_count;
      end
    end
  end

  assign flush = seq_in.seq_end && run_open_next;

  always_comb begin
    push_data.r0.run_first    = to_out(emit_old ? run_begin : run_begin_next);
    push_data.r0.run_final    = to_out(emit_old ? run_stop : run_stop_next);
    push_data.r0.last_of_item = !(emit_old && flush);
    push_data.r1.run_first    = to_out(run_begin_next);
    push_data.r1.run_final    = to_out(run_stop_next);
    push_data.r1.last_of_item = 1'b1;
    push_data.num             = 2'(emit_old) + 2'(flush);
  end

  assign push = accept && (emit_old || flush);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < HIST_DEPTH; k++) recent[k] <= CODE_NOMATCH;
      position_count <= '0;
      run_open       <= 1'b0;
      run_begin      <= '0;
      run_stop       <= '0;
    end else if (accept) begin
      if (seq_in.seq_end) begin
        // fresh sequence follows
        for (int k = 0; k < HIST_DEPTH; k++) recent[k] <= CODE_NOMATCH;
        position_count <= '0;
        run_open       <= 1'b0;
        run_begin      <= '0;
        run_stop       <= '0;
      end else begin
        recent[0] <= recent[1];
        recent[1] <= recent[2];
        recent[2] <= code;
        if (position_count != POS_MAX) begin
          position_count <= position_count + POS_BITS'(1);
        end
        run_open  <= run_open_next;
        run_begin <= run_begin_next;
        run_stop  <= run_stop_next;
      end
    end
  end

endmodule

// ===== hdl/dthm_queue.sv =====
// ----------------------------------------------------------------------------
// dthm_queue
// Short result queue: takes up to two results a cycle, gives one.
// ----------------------------------------------------------------------------
module dthm_queue import dthm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  dthm_push_t   push_data,
  output logic         space_ok,
  input  logic         pop,
  output logic         head_valid,
  output dthm_result_t head
);

  dthm_result_t         entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;
  logic [QCNT_BITS-1:0] push_num;
  logic                 pop_ok;

  assign space_ok   = count <= QCNT_BITS'(QUEUE_DEPTH - 2);
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];
  assign pop_ok     = pop && head_valid;
  assign push_num   = push ? QCNT_BITS'(push_data.num) : '0;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data.r0;
      if (push_data.num == 2'd2) begin
        entries[wr_ptr + QPTR_BITS'(1)] <= push_data.r1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_BITS'(push_num);
      if (pop_ok) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      count <= count + push_num - QCNT_BITS'(pop_ok);
    end
  end

endmodule

// ===== hdl/dthm_back.sv =====
// ----------------------------------------------------------------------------
// dthm_back
// Output register: present the queue head on the run channel.
// ----------------------------------------------------------------------------
module dthm_back import dthm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         head_valid,
  input  dthm_result_t head,
  output logic         pop,
  dthm_out_if.source   run_out
);

  logic         out_valid;
  dthm_result_t out_data;

  // load when the register is empty or its item leaves this cycle
  assign pop = head_valid && (!out_valid || run_out.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (run_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= head;
    end
  end

  assign run_out.valid        = out_valid;
  assign run_out.run_first    = out_data.run_first;
  assign run_out.run_final    = out_data.run_final;
  assign run_out.last_of_item = out_data.last_of_item;

endmodule

// ===== hdl/degenerate_tetramer_hit_merger_core.sv =====
// ----------------------------------------------------------------------------
// degenerate_tetramer_hit_merger_core
// Degenerate four-base motif scanner that merges overlapping hits into runs.
// ----------------------------------------------------------------------------
// Usage:
//   seq_in  carries one sequence byte per item (base_char) and seq_end on the
//           final byte of a sequence. Each position of the motif has a mask
//           of allowed bases (bit0 A, bit1 C, bit2 G, bit3 T), written over
//           the APB port at byte addresses 0, 4, 8 and 12 while idle.
//   run_out carries merged runs (run_first, run_final, 0-based positions);
//           last_of_item marks the final run caused by one input byte, and
//           one byte causes at most two runs.
// Throughput: one byte per cycle while seq_in.ready is high. The front updates
//   the window and run state in the cycle it accepts a byte and pushes its
//   runs into a four-entry queue; the back drains one run per cycle, while
//   run_out is ready, into the output register that drives run_out.
// Stall: when run_out is not ready the queue fills; seq_in.ready drops while
//   fewer than two entries are free, and rises again as runs drain.
// Reset: masks return to 1 (A only), the window, position and pending run
//   clear, and the queue and output register empty.
// ----------------------------------------------------------------------------
module degenerate_tetramer_hit_merger_core import dthm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  dthm_in_if.sink              seq_in,
  dthm_out_if.source           run_out,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  dthm_masks_t  masks;
  dthm_push_t   push_data;
  dthm_result_t head;
  logic         push;
  logic         space_ok;
  logic         pop;
  logic         head_valid;
  logic         cfg_write;

  // configuration registers: written in the access phase, no wait states
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      masks.pos0 <= MASK_RESET;
      masks.pos1 <= MASK_RESET;
      masks.pos2 <= MASK_RESET;
      masks.pos3 <= MASK_RESET;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_POS0: masks.pos0 <= pwdata[MASK_BITS-1:0];
        REG_POS1: masks.pos1 <= pwdata[MASK_BITS-1:0];
        REG_POS2: masks.pos2 <= pwdata[MASK_BITS-1:0];
        REG_POS3: masks.pos3 <= pwdata[MASK_BITS-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_POS0: prdata = DATA_BITS'(masks.pos0);
      REG_POS1: prdata = DATA_BITS'(masks.pos1);
      REG_POS2: prdata = DATA_BITS'(masks.pos2);
      REG_POS3: prdata = DATA_BITS'(masks.pos3);
      default:  prdata = '0;
    endcase
  end

  // front: accept bytes, match the window, merge hits into runs
  dthm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .masks     (masks),
    .space_ok  (space_ok),
    .seq_in    (seq_in),
    .push      (push),
    .push_data (push_data)
  );

  // queue: decouple run production from the receiver
  dthm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .space_ok   (space_ok),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // back: hold each run in the output register until taken
  dthm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .run_out    (run_out)
  );

endmodule

// ===== tb/tb_degenerate_tetramer_hit_merger_core.sv =====
// ----------------------------------------------------------------------------
// tb_degenerate_tetramer_hit_merger_core
// Self-checking bench for the degenerate tetramer hit merger: sequence bytes
// go in over seq_in, merged hit runs are predicted on acceptance and checked
// in order against run_out, over several mask settings written through APB.
// ----------------------------------------------------------------------------
module tb_degenerate_tetramer_hit_merger_core;
  import dthm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // --------------------------------------------------------------------------
  // Run predictor and scoreboard. The window, position and pending run are
  // tracked here on every accepted byte; expected runs wait in a queue until
  // run_out delivers them.
  // --------------------------------------------------------------------------
  class run_book;
    dthm_masks_t          masks;
    logic [CODE_BITS-1:0] window [HIST_DEPTH];  // [0] oldest, [2] newest
    logic [POS_BITS-1:0]  next_pos;
    bit                   open;
    logic [POS_BITS-1:0]  first_pos;
    logic [POS_BITS-1:0]  final_pos;
    dthm_result_t         due [$];
    int                   errors;
    int                   checked;

    function new();
      masks = '{pos0: MASK_RESET, pos1: MASK_RESET, pos2: MASK_RESET, pos3: MASK_RESET};
      errors = 0;
      checked = 0;
      clear();
    endfunction

    function void clear();
      foreach (window[k]) window[k] = CODE_NOMATCH;
      next_pos = '0;
      open = 1'b0;
      first_pos = '0;
      final_pos = '0;
    endfunction

    function void set_mask(logic [1:0] idx, logic [DATA_BITS-1:0] v);
      case (idx)
        REG_POS0: masks.pos0 = v[MASK_BITS-1:0];
        REG_POS1: masks.pos1 = v[MASK_BITS-1:0];
        REG_POS2: masks.pos2 = v[MASK_BITS-1:0];
        REG_POS3: masks.pos3 = v[MASK_BITS-1:0];
        default:  ;
      endcase
    endfunction

    function logic [CODE_BITS-1:0] code_of(logic [7:0] c);
      case (c)
        CHAR_A:  return CODE_A;
        CHAR_C:  return CODE_C;
        CHAR_G:  return CODE_G;
        CHAR_T:  return CODE_T;
        default: return CODE_NOMATCH;
      endcase
    endfunction

    function bit fits(logic [CODE_BITS-1:0] code, logic [MASK_BITS-1:0] m);
      return code != CODE_NOMATCH && m[code[1:0]];
    endfunction

    function dthm_result_t make_run();
      dthm_result_t r;
      r.run_first = first_pos;
      r.run_final = final_pos;
      r.last_of_item = 1'b0;
      return r;
    endfunction

    // Advance the window by one byte and queue the runs it closes.
    function void note_byte(logic [7:0] c, logic seq_end);
      logic [CODE_BITS-1:0] code;
      logic [POS_BITS:0]    start;
      bit                   hit;
      dthm_result_t         made [$];
      code = code_of(c);
      hit = fits(window[0], masks.pos0) && fits(window[1], masks.pos1) &&
            fits(window[2], masks.pos2) && fits(code, masks.pos3) && next_pos >= 3;
      if (hit) begin
        start = {1'b0, next_pos} - 3;
        if (open && start <= {1'b0, final_pos} + 1'b1) begin
          if (next_pos > final_pos) final_pos = next_pos;
        end else begin
          if (open) made.insert(made.size(), make_run());
          open = 1'b1;
          first_pos = start[POS_BITS-1:0];
          final_pos = next_pos;
        end
      end
      window[0] = window[1];
      window[1] = window[2];
      window[2] = code;
      if (next_pos != POS_MAX) next_pos++;
      if (seq_end) begin
        if (open) made.insert(made.size(), make_run());
        clear();
      end
      if (made.size() > 0) made[made.size()-1].last_of_item = 1'b1;
      foreach (made[k]) due.insert(due.size(), made[k]);
    endfunction

    function void check_run(logic [OUT_BITS-1:0] first, logic [OUT_BITS-1:0] final_p,
                            logic last);
      dthm_result_t want;
      if (due.size() == 0) begin
        $error("unexpected run: run_first %0d run_final %0d last_of_item %0b",
               first, final_p, last);
        errors++;
        return;
      end
      want = due.pop_front();
      checked++;
      if (first !== want.run_first) begin
        $error("run_first: expected %0d, got %0d", want.run_first, first);
        errors++;
      end
      if (final_p !== want.run_final) begin
        $error("run_final: expected %0d, got %0d", want.run_final, final_p);
        errors++;
      end
      if (last !== want.last_of_item) begin
        $error("last_of_item: expected %0b, got %0b", want.last_of_item, last);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block itself.
  // --------------------------------------------------------------------------
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;
  bit                   jitter = 1'b1;  // random idling on both sides

  dthm_in_if  seq_if ();
  dthm_out_if run_if ();

  run_book book = new();

  int n_bytes    = 0;
  int n_seqs     = 0;
  int n_settings = 0;

  // Opening sequence under the reset masks (A at every position): a run
  // broken by a zero byte, a run broken by 0xFF, and a final byte whose new
  // match does not join, so it closes the old run and flushes the new one.
  logic [7:0] opening [15] = '{CHAR_A, CHAR_A, CHAR_A, CHAR_A, 8'h00,
                               CHAR_A, CHAR_A, CHAR_A, CHAR_A, CHAR_A, 8'hFF,
                               CHAR_A, CHAR_A, CHAR_A, CHAR_A};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  degenerate_tetramer_hit_merger_core dut (
    .clk     (clk),
    .rst     (rst),
    .seq_in  (seq_if),
    .run_out (run_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Stall the result side at random, about 8 percent of the time, while jitter is on.
  always @(posedge clk) begin
    run_if.ready <= !(jitter && $urandom_range(99) < 8);
  end

  // Check every run that leaves the block against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && run_if.valid && run_if.ready) begin
      book.check_run(run_if.run_first, run_if.run_final, run_if.last_of_item);
    end
  end

  // Hard stop in case the handshakes hang.
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Read a mask register back and compare with the value it should hold.
  task automatic read_check(input logic [1:0] idx, input logic [MASK_BITS-1:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {{(DATA_BITS-MASK_BITS){1'b0}}, want}) begin
      $error("prdata: expected %0h, got %0h", want, prdata);
      book.errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write one mask register (setup, then access), then read it back.
  task automatic write_reg(input logic [1:0] idx, input logic [DATA_BITS-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    book.set_mask(idx, value);
    read_check(idx, value[MASK_BITS-1:0]);
  endtask

  task automatic write_masks(input logic [DATA_BITS-1:0] m0, input logic [DATA_BITS-1:0] m1,
                             input logic [DATA_BITS-1:0] m2, input logic [DATA_BITS-1:0] m3);
    write_reg(REG_POS0, m0);
    write_reg(REG_POS1, m1);
    write_reg(REG_POS2, m2);
    write_reg(REG_POS3, m3);
    n_settings++;
  endtask

  // Offer one byte, idling at random first; return once it is accepted.
  task automatic send_byte(input logic [7:0] c, input logic last);
    while (jitter && $urandom_range(99) < 8) begin
      seq_if.valid <= 1'b0;
      @(posedge clk);
    end
    seq_if.valid <= 1'b1;
    seq_if.base_char <= c;
    seq_if.seq_end <= last;
    do @(posedge clk); while (!seq_if.ready);
    book.note_byte(c, last);
    n_bytes++;
    if (last) n_seqs++;
  endtask

  // Hold the input idle until every expected run has come out, then let the
  // pipeline settle so that no byte is still in flight.
  task automatic drain();
    seq_if.valid <= 1'b0;
    while (book.due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Pick a byte that the mask of one motif position allows, or any base if that mask is zero.
  function automatic logic [7:0] motif_char(input int slot);
    logic [MASK_BITS-1:0] m;
    logic [1:0]           b;
    case (slot)
      0:       m = book.masks.pos0;
      1:       m = book.masks.pos1;
      2:       m = book.masks.pos2;
      default: m = book.masks.pos3;
    endcase
    b = 2'($urandom_range(3));
    if (m != '0) begin
      while (!m[b]) b = 2'($urandom_range(3));
    end
    case (b)
      2'd0:    return CHAR_A;
      2'd1:    return CHAR_C;
      2'd2:    return CHAR_G;
      default: return CHAR_T;
    endcase
  endfunction

  // Mostly plain bases, now and then any byte at all.
  function automatic logic [7:0] filler_char();
    if ($urandom_range(99) < 20) return 8'($urandom_range(255));
    case ($urandom_range(3))
      0:       return CHAR_A;
      1:       return CHAR_C;
      2:       return CHAR_G;
      default: return CHAR_T;
    endcase
  endfunction

  // One sequence: motif instances planted among filler, seq_end on the last byte.
  task automatic send_sequence(input int len);
    int k;
    int j;
    k = 0;
    while (k < len) begin
      if ($urandom_range(99) < 40 && k + 4 <= len) begin
        for (j = 0; j < 4; j++) begin
          send_byte(motif_char(j), k == len - 1);
          k++;
        end
      end else begin
        send_byte(filler_char(), k == len - 1);
        k++;
      end
    end
  endtask

  function automatic int pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 10) return $urandom_range(1, 3);
    if (r < 90) return $urandom_range(4, 24);
    return $urandom_range(25, 60);
  endfunction

  function automatic logic [DATA_BITS-1:0] random_mask();
    return DATA_BITS'($urandom_range(1, 15));
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int phase;
    int budget;
    seq_if.valid = 1'b0;
    seq_if.base_char = 8'h00;
    seq_if.seq_end = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Masks must come out of reset as A only.
    read_check(REG_POS0, MASK_RESET);
    read_check(REG_POS1, MASK_RESET);
    read_check(REG_POS2, MASK_RESET);
    read_check(REG_POS3, MASK_RESET);

    // Directed: extreme bytes, run breaks, two runs on one byte, an end byte
    // with nothing pending, lower case and the other bases.
    foreach (opening[k]) send_byte(opening[k], k == 14);
    send_byte(CHAR_C, 1'b1);
    send_byte(8'h61, 1'b0);
    send_byte(CHAR_G, 1'b0);
    send_byte(CHAR_T, 1'b1);
    drain();

    // Random phases, each under its own mask setting.
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: write_masks(32'hF, 32'hF, 32'hF, 32'hF);          // any base anywhere
        1: write_masks(32'h1, 32'h1, 32'h1, 32'h1);          // lowest masks
        2: write_masks(32'h5, 32'hA, 32'h6, 32'h9);          // R Y S W
        3: write_masks(32'hFFFF_FFF9, 32'hA5A5_A5A6,         // W S Y R, upper bits set
                       32'h5A5A_5A5A, 32'hFFFF_FFF5);
        4: write_masks(32'h3, 32'hC, 32'hFFFF_FFF0, 32'hF);  // zero mask: no hits
        default: write_masks(random_mask(), random_mask(), random_mask(), random_mask());
      endcase
      // One phase runs with no idling on either side.
      jitter <= (phase != 5);
      budget = n_bytes + 200;
      while (n_bytes < budget) begin
        send_sequence(pick_length());
        // In one phase only, let everything drain before sending on.
        if (phase == 6 && n_bytes >= budget - 100 && n_bytes < budget - 70) drain();
      end
      drain();
      jitter <= 1'b1;
    end

    // Final settle, bounded by the timeout above.
    repeat (10) @(posedge clk);
    $display("covered %0d bytes in %0d sequences under %0d mask settings",
             n_bytes, n_seqs, n_settings + 1);
    $display("checked %0d merged runs, %0d mismatches", book.checked, book.errors);
    if (book.errors == 0 && book.due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
